@@ rtl/hekw_pkg.sv @@
// ----------------------------------------------------------------------------
// hekw_pkg
// Shared types and constants of the exponential kernel weight block: the
// controller states, the datapath operations and the command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package hekw_pkg;

    // Item kinds.
    localparam logic [1:0] KIND_SOURCE  = 2'd0;
    localparam logic [1:0] KIND_TARGET  = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;
    localparam logic [1:0] KIND_RESTART = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_DECAY_0       = 3'd0;
    localparam logic [2:0] REG_DECAY_1       = 3'd1;
    localparam logic [2:0] REG_DECAY_2       = 3'd2;
    localparam logic [2:0] REG_DECAY_3       = 3'd3;
    localparam logic [2:0] REG_DECAYS_IN_USE = 3'd4;

    localparam logic [23:0] DECAY_RESET  = 24'h01_0000;
    localparam logic [32:0] ONE_Q32      = 33'h1_0000_0000;
    localparam logic [31:0] EXP_M1_Q32   = 32'h5E2D_58D9;
    localparam logic [47:0] MAX48        = 48'hFFFF_FFFF_FFFF;
    localparam logic [55:0] MAX56        = 56'hFF_FFFF_FFFF_FFFF;
    localparam logic [32:0] EXP_LIMIT    = 33'd23;
    localparam logic [4:0]  SERIES_TERMS = 5'd13;

    // Reciprocals floor(2^35 / k) for the series divisions by k = 1..13.
    localparam logic [35:0] RECIP_TBL [16] = '{
        36'd0,
        36'(64'h8_0000_0000 / 1),  36'(64'h8_0000_0000 / 2),
        36'(64'h8_0000_0000 / 3),  36'(64'h8_0000_0000 / 4),
        36'(64'h8_0000_0000 / 5),  36'(64'h8_0000_0000 / 6),
        36'(64'h8_0000_0000 / 7),  36'(64'h8_0000_0000 / 8),
        36'(64'h8_0000_0000 / 9),  36'(64'h8_0000_0000 / 10),
        36'(64'h8_0000_0000 / 11), 36'(64'h8_0000_0000 / 12),
        36'(64'h8_0000_0000 / 13),
        36'd0, 36'd0
    };

    typedef enum logic [4:0] {
        ST_IDLE, ST_X_LO, ST_X_HI, ST_P, ST_T_MUL, ST_T_DIV, ST_T_FIX, ST_E,
        ST_SEG_LO, ST_SEG_HI, ST_SEG_ADD, ST_C_LO, ST_C_HI, ST_C_ADD,
        ST_G_LO, ST_G_HI, ST_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_START, OP_X_LO, OP_X_HI, OP_P, OP_T_MUL, OP_T_DIV, OP_T_FIX,
        OP_E, OP_SEG_LO, OP_SEG_HI, OP_SEG_ADD, OP_C_LO, OP_C_HI, OP_C_ADD,
        OP_G_LO, OP_G_HI, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] u;
        logic [3:0] k;
        logic       out;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic       exp_big;
        logic [4:0] exp_int;
        logic [1:0] kind;
        logic [2:0] n_use;
    } t_dp_status;

endpackage

`default_nettype wire

@@ rtl/hekw_dp.sv @@
// ----------------------------------------------------------------------------
// hekw_dp
// Datapath: configuration registers, per-decay state, and one shared
// multiplier that serves the exp evaluation and all fixed-point products.
// ----------------------------------------------------------------------------
`default_nettype none

module hekw_dp #(
    parameter int MAX_DECAYS = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire hekw_pkg::t_dp_cmd     i_cmd,
    output hekw_pkg::t_dp_status       o_sts,
    input  wire logic                  i_cfg_valid,
    input  wire logic [2:0]            i_cfg_index,
    input  wire logic [23:0]           i_cfg_data,
    input  wire logic [1:0]            i_kind,
    input  wire logic [39:0]           i_event_time,
    output logic [1:0]                 o_decay_index,
    output logic [55:0]                o_intensity_value,
    output logic [47:0]                o_interval_integral,
    output logic [55:0]                o_integral_total,
    output logic                       o_at_window_end,
    output logic                       o_last
);
    import hekw_pkg::*;

    localparam int UW = (MAX_DECAYS > 1) ? $clog2(MAX_DECAYS) : 1;

    logic [23:0]        r_decay [4];
    logic [2:0]         r_use;
    logic [47:0]        r_cnt_st [MAX_DECAYS];
    logic [47:0]        r_seg [MAX_DECAYS];
    logic [55:0]        r_tot [MAX_DECAYS];
    logic [39:0]        r_last_time;
    logic [1:0]         r_kind;
    logic [39:0]        r_d;
    logic [55:0]        r_xlo;
    logic [32:0]        r_nf;
    logic [32:0]        r_p;
    logic [32:0]        r_t;
    logic [31:0]        r_q;
    logic signed [35:0] r_s;
    logic [32:0]        r_e;
    logic [49:0]        r_acc;
    logic [55:0]        r_g;

    logic [UW-1:0]      idx;
    logic [23:0]        dec;
    logic [47:0]        cval;
    logic [32:0]        mval;
    logic [32:0]        sclamp;
    logic [32:0]        mul_a;
    logic [35:0]        mul_b;
    logic [68:0]        mul_p;
    logic [36:0]        qk;
    logic [36:0]        rem;
    logic [31:0]        q_fix;
    logic [48:0]        seg_sum;
    logic [48:0]        src_sum;
    logic [56:0]        tot_sum;
    logic [55:0]        tot_new;

    assign idx  = i_cmd.u[UW-1:0];
    assign dec  = r_decay[i_cmd.u];
    assign cval = r_cnt_st[idx];
    assign mval = ONE_Q32 - r_e;

    always_comb begin
        if (r_s < 36'sd0) begin
            sclamp = 33'd0;
        end else if (r_s > $signed({3'b000, ONE_Q32})) begin
            sclamp = ONE_Q32;
        end else begin
            sclamp = r_s[32:0];
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = 33'd0;
        mul_b = 36'd0;
        case (i_cmd.op)
            OP_X_LO:   begin mul_a = 33'(r_d[31:0]);   mul_b = 36'(dec);               end
            OP_X_HI:   begin mul_a = 33'(r_d[39:32]);  mul_b = 36'(dec);               end
            OP_P:      begin mul_a = r_p;              mul_b = 36'(EXP_M1_Q32);        end
            OP_T_MUL:  begin mul_a = r_t;              mul_b = 36'(r_xlo[31:0]);       end
            OP_T_DIV:  begin mul_a = r_t;              mul_b = RECIP_TBL[i_cmd.k];     end
            OP_E:      begin mul_a = r_p;              mul_b = 36'(sclamp);            end
            OP_SEG_LO: begin mul_a = 33'(cval[31:0]);  mul_b = 36'(mval);              end
            OP_SEG_HI: begin mul_a = 33'(cval[47:32]); mul_b = 36'(mval);              end
            OP_C_LO:   begin mul_a = 33'(cval[31:0]);  mul_b = 36'(r_e);               end
            OP_C_HI:   begin mul_a = 33'(cval[47:32]); mul_b = 36'(r_e);               end
            OP_G_LO:   begin mul_a = 33'(cval[23:0]);  mul_b = 36'(dec);               end
            OP_G_HI:   begin mul_a = 33'(cval[47:24]); mul_b = 36'(dec);               end
            default:   begin mul_a = 33'd0;            mul_b = 36'd0;                  end
        endcase
    end

    assign mul_p = 69'(mul_a) * 69'(mul_b);

    // Correction of the reciprocal quotient: it is low by at most one.
    assign qk    = 37'(r_q) * 37'(i_cmd.k);
    assign rem   = 37'(r_t) - qk;
    assign q_fix = (rem >= 37'(i_cmd.k)) ? r_q + 32'd1 : r_q;

    assign seg_sum = 49'(r_seg[idx]) + 49'(r_acc[47:0]);
    assign src_sum = 49'(r_acc[47:0]) + 49'(ONE_Q32);
    assign tot_sum = 57'(r_tot[idx]) + 57'(r_seg[idx]);
    assign tot_new = (tot_sum > 57'(MAX56)) ? MAX56 : tot_sum[55:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_decay[i] <= DECAY_RESET;
            end
            r_use       <= 3'd1;
            r_last_time <= 40'd0;
            r_kind      <= KIND_SOURCE;
            for (int i = 0; i < MAX_DECAYS; i++) begin
                r_cnt_st[i] <= 48'd0;
                r_seg[i]    <= 48'd0;
                r_tot[i]    <= 56'd0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_DECAY_0:       r_decay[0] <= i_cfg_data;
                    REG_DECAY_1:       r_decay[1] <= i_cfg_data;
                    REG_DECAY_2:       r_decay[2] <= i_cfg_data;
                    REG_DECAY_3:       r_decay[3] <= i_cfg_data;
                    REG_DECAYS_IN_USE: r_use      <= i_cfg_data[2:0];
                    default:           r_use      <= r_use;
                endcase
            end
            case (i_cmd.op)
                OP_START: begin
                    r_kind <= i_kind;
                    if (i_kind == KIND_RESTART) begin
                        r_last_time <= 40'd0;
                        for (int i = 0; i < MAX_DECAYS; i++) begin
                            r_cnt_st[i] <= 48'd0;
                            r_seg[i]    <= 48'd0;
                            r_tot[i]    <= 56'd0;
                        end
                    end else begin
                        r_last_time <= i_event_time;
                    end
                end
                OP_SEG_ADD: r_seg[idx] <= (seg_sum > 49'(MAX48)) ? MAX48 : seg_sum[47:0];
                OP_C_ADD: begin
                    if (r_kind == KIND_SOURCE) begin
                        r_cnt_st[idx] <= (src_sum > 49'(MAX48)) ? MAX48 : src_sum[47:0];
                    end else begin
                        r_cnt_st[idx] <= r_acc[47:0];
                    end
                end
                OP_EMIT: begin
                    r_tot[idx] <= tot_new;
                    r_seg[idx] <= 48'd0;
                end
                default: r_kind <= r_kind;
            endcase
        end
    end

    // Working registers of the exp evaluation and products.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_START: r_d <= (i_event_time >= r_last_time) ? i_event_time - r_last_time
                                                           : 40'd0;
            OP_X_LO:  r_xlo <= mul_p[55:0];
            OP_X_HI: begin
                r_nf <= 33'(mul_p[31:0]) + 33'(r_xlo[55:32]);
                r_p  <= ONE_Q32;
                r_t  <= ONE_Q32;
                r_s  <= 36'(ONE_Q32);
            end
            OP_P:     r_p <= mul_p[64:32];
            OP_T_MUL: r_t <= {1'b0, mul_p[63:32]};
            OP_T_DIV: r_q <= mul_p[66:35];
            OP_T_FIX: begin
                r_t <= 33'(q_fix);
                if (i_cmd.k[0]) begin
                    r_s <= r_s - $signed(36'(q_fix));
                end else begin
                    r_s <= r_s + $signed(36'(q_fix));
                end
            end
            OP_E:      r_e   <= o_sts.exp_big ? 33'd0 : mul_p[64:32];
            OP_SEG_LO: r_acc <= 50'(mul_p[64:32]);
            OP_SEG_HI: r_acc <= 50'(mul_p[48:0]) + r_acc;
            OP_C_LO:   r_acc <= 50'(mul_p[64:32]);
            OP_C_HI:   r_acc <= 50'(mul_p[48:0]) + r_acc;
            OP_G_LO:   r_acc <= 50'(mul_p[47:16]);
            OP_G_HI:   r_g   <= 56'({mul_p[47:0], 8'd0}) + 56'(r_acc[31:0]);
            OP_EMIT: begin
                if (i_cmd.out) begin
                    o_decay_index       <= i_cmd.u;
                    o_intensity_value   <= (r_kind == KIND_END) ? 56'd0 : r_g;
                    o_interval_integral <= r_seg[idx];
                    o_integral_total    <= tot_new;
                    o_at_window_end     <= (r_kind == KIND_END);
                    o_last              <= i_cmd.last;
                end
            end
            default: r_q <= r_q;
        endcase
    end

    always_comb begin
        o_sts.exp_big = (r_nf >= EXP_LIMIT);
        o_sts.exp_int = r_nf[4:0];
        o_sts.kind    = r_kind;
        if (r_use == 3'd0) begin
            o_sts.n_use = 3'd1;
        end else if (r_use > 3'(MAX_DECAYS)) begin
            o_sts.n_use = 3'(MAX_DECAYS);
        end else begin
            o_sts.n_use = r_use;
        end
    end

    a_div_fix_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_T_FIX) |-> (rem < 37'({i_cmd.k, 1'b0})))
        else $error("series quotient off by more than one");

    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_E) |=> (r_e <= ONE_Q32))
        else $error("exp result above one");

endmodule

`default_nettype wire

@@ rtl/hekw_ctrl.sv @@
// ----------------------------------------------------------------------------
// hekw_ctrl
// Controller: sequences the datapath through the per-decay steps, holds the
// result valid flag and the input stall.
// ----------------------------------------------------------------------------
`default_nettype none

module hekw_ctrl #(
    parameter int MAX_DECAYS = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [1:0]           i_kind,
    output logic                      o_stall,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    input  wire hekw_pkg::t_dp_status i_sts,
    output hekw_pkg::t_dp_cmd         o_cmd
);
    import hekw_pkg::*;

    localparam int UW = (MAX_DECAYS > 1) ? $clog2(MAX_DECAYS) : 1;
    localparam logic [UW-1:0] LAST_U = UW'(MAX_DECAYS - 1);

    t_state        r_state, n_state;
    logic [UW-1:0] r_u, n_u;
    logic [4:0]    r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          out_en;
    logic          emit_ok;

    assign out_en  = (3'(r_u) < i_sts.n_use);
    assign emit_ok = !(r_out_valid && i_stall);
    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_u     = r_u;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_u     = '0;
                    n_state = (i_kind == KIND_RESTART) ? ST_IDLE : ST_X_LO;
                end
            end
            ST_X_LO: n_state = ST_X_HI;
            ST_X_HI: begin
                n_state = ST_P;
                n_cnt   = 5'd0;
            end
            ST_P: begin
                if (i_sts.exp_big) begin
                    n_state = ST_E;
                end else if (r_cnt == i_sts.exp_int) begin
                    n_state = ST_T_MUL;
                    n_cnt   = 5'd1;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            ST_T_MUL: n_state = ST_T_DIV;
            ST_T_DIV: n_state = ST_T_FIX;
            ST_T_FIX: begin
                if (r_cnt == SERIES_TERMS) begin
                    n_state = ST_E;
                end else begin
                    n_state = ST_T_MUL;
                    n_cnt   = r_cnt + 5'd1;
                end
            end
            ST_E:       n_state = ST_SEG_LO;
            ST_SEG_LO:  n_state = ST_SEG_HI;
            ST_SEG_HI:  n_state = ST_SEG_ADD;
            ST_SEG_ADD: n_state = ST_C_LO;
            ST_C_LO:    n_state = ST_C_HI;
            ST_C_HI:    n_state = ST_C_ADD;
            ST_C_ADD: begin
                if (i_sts.kind == KIND_SOURCE) begin
                    n_state = (r_u == LAST_U) ? ST_IDLE : ST_X_LO;
                    n_u     = (r_u == LAST_U) ? r_u : r_u + UW'(1);
                end else begin
                    n_state = ST_G_LO;
                end
            end
            ST_G_LO: n_state = ST_G_HI;
            ST_G_HI: n_state = ST_EMIT;
            ST_EMIT: begin
                if (!out_en || emit_ok) begin
                    n_state = (r_u == LAST_U) ? ST_IDLE : ST_X_LO;
                    n_u     = (r_u == LAST_U) ? r_u : r_u + UW'(1);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.u    = 2'(r_u);
        o_cmd.k    = r_cnt[3:0];
        o_cmd.out  = 1'b0;
        o_cmd.last = (3'(r_u) == i_sts.n_use - 3'd1);
        case (r_state)
            ST_IDLE:    o_cmd.op = i_valid ? OP_START : OP_NONE;
            ST_X_LO:    o_cmd.op = OP_X_LO;
            ST_X_HI:    o_cmd.op = OP_X_HI;
            ST_P: begin
                if (!i_sts.exp_big && (r_cnt != i_sts.exp_int)) begin
                    o_cmd.op = OP_P;
                end
            end
            ST_T_MUL:   o_cmd.op = OP_T_MUL;
            ST_T_DIV:   o_cmd.op = OP_T_DIV;
            ST_T_FIX:   o_cmd.op = OP_T_FIX;
            ST_E:       o_cmd.op = OP_E;
            ST_SEG_LO:  o_cmd.op = OP_SEG_LO;
            ST_SEG_HI:  o_cmd.op = OP_SEG_HI;
            ST_SEG_ADD: o_cmd.op = OP_SEG_ADD;
            ST_C_LO:    o_cmd.op = OP_C_LO;
            ST_C_HI:    o_cmd.op = OP_C_HI;
            ST_C_ADD:   o_cmd.op = OP_C_ADD;
            ST_G_LO:    o_cmd.op = OP_G_LO;
            ST_G_HI:    o_cmd.op = OP_G_HI;
            ST_EMIT: begin
                if (!out_en || emit_ok) begin
                    o_cmd.op  = OP_EMIT;
                    o_cmd.out = out_en;
                end
            end
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    always_comb begin
        if (o_cmd.op == OP_EMIT && o_cmd.out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_u         <= '0;
            r_cnt       <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_u         <= n_u;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    a_start_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_valid && i_kind != KIND_RESTART) |=> (r_state == ST_X_LO))
        else $error("accepted item did not start the decay sequence");

    a_pow_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_P && !i_sts.exp_big) |-> (r_cnt <= 5'd22))
        else $error("exp integer power count out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_EMIT && o_cmd.out) |-> !(r_out_valid && i_stall))
        else $error("result written over a pending result");

endmodule

`default_nettype wire

@@ rtl/hawkes_exp_kernel_weights.sv @@
// ----------------------------------------------------------------------------
// hawkes_exp_kernel_weights
// Sum-of-exponentials Hawkes kernel weights for one target/source node pair.
// ----------------------------------------------------------------------------
// Usage: items (kind, event_time) enter on the input channel; an item is
// taken when i_valid is high and o_stall is low. Each non-restart item runs
// every decay slot through one shared exp/multiply datapath. A target event
// or window end then gives one result item per decay in use, in order of
// decay index, with o_last on the final one; source events and restarts give
// none. A result is taken when o_valid is high and i_stall is low.
// Steps: per decay slot the block scales the elapsed time by the decay rate,
// multiplies by e^-1 n times, where n (0..22) is the integer part of decay *
// elapsed time, and evaluates the 13-term exp series of the fraction on the
// single multiplier; a slot whose exponent reaches 23 skips both. A restart
// clears the per-decay state and runs no decay slot.
// The configuration channel (i_cfg_*) is always ready; write it only while
// the block is idle. Reset is synchronous, clears the controller and per-decay
// state, sets the decay rates to 1.0 and decays in use to one. A stalled result
// holds the output; the block waits before writing the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module hawkes_exp_kernel_weights #(
    parameter int MAX_DECAYS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [39:0] i_event_time,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_decay_index,
    output logic [55:0]      o_intensity_value,
    output logic [47:0]      o_interval_integral,
    output logic [55:0]      o_integral_total,
    output logic             o_at_window_end,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);
    import hekw_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status sts;

    // Configuration writes complete in the cycle they are offered.
    assign o_cfg_ready = 1'b1;

    hekw_ctrl #(
        .MAX_DECAYS (MAX_DECAYS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    hekw_dp #(
        .MAX_DECAYS (MAX_DECAYS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_cfg_valid         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_kind              (i_kind),
        .i_event_time        (i_event_time),
        .o_decay_index       (o_decay_index),
        .o_intensity_value   (o_intensity_value),
        .o_interval_integral (o_interval_integral),
        .o_integral_total    (o_integral_total),
        .o_at_window_end     (o_at_window_end),
        .o_last              (o_last)
    );

    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_START) |-> (i_valid && !o_stall))
        else $error("item started without an input handshake");

    a_end_no_g: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_at_window_end) |-> (o_intensity_value == 56'd0))
        else $error("window end result carries an intensity");

    a_index_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (3'(o_decay_index) < sts.n_use))
        else $error("result for a decay that is not in use");

endmodule

`default_nettype wire
